// ----- hdl/bra_pkg.sv -----
// Shared types and codes for the bitmap run allocator.
// This file depends on nothing. Every other file in hdl but bra_ram imports it.
package bra_pkg;

    // Width of block positions, sizes and the search hint.
    localparam int PW = 17;
    // Bits examined per scan step.
    localparam int STEP = 8;
    localparam logic [7:0] STEP_MASK = 8'hff;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_MARK  = 2'd2;
    localparam logic [1:0] MODE_TEST  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BOUNDS   = 2'd2;

    typedef struct packed {
        logic          found;
        logic [PW-1:0] start;
        logic [PW-1:0] count;
        logic [PW-1:0] next_pos;
    } t_scan_res;

endpackage

// ----- hdl/bitmap_run_allocator_top.sv -----
// Top level of the bitmap run allocator: sequencer, hint and result registers.
// Depends on bra_pkg, bra_ram and bra_scan.
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+-----------------------
//   command  | i_mode, i_block_index, i_run_length            | i_start & !o_busy
//   result   | o_status, o_start_block, o_bit_value           | o_done, one cycle
//   config   | i_cfg_bitmap_size                              | i_cfg_valid & o_cfg_ready
//
// After reset a clearing pass writes every bitmap word (DEPTH words, 2048 by
// default) to all ones, one word a cycle; o_busy stays high meanwhile. Test
// reads its word and then answers; free and mark read and write back each touched
// word; out-of-bounds, empty-range and zero-length items answer straight from idle.
// Allocate reads each scanned word, scans it in groups of up to eight bits, then
// reads and writes back each marked word; the single RAM port and the eight-bit scan step set this order.
// Results cannot be stalled: o_done marks each item for exactly one cycle.
module bitmap_run_allocator_top #(
    parameter int MAX_BLOCKS = 65536,
    parameter int WORD_BITS  = 32      // power of two
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_block_index,
    input  logic [15:0] i_run_length,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_start_block,
    output logic        o_bit_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_bitmap_size
);
    import bra_pkg::*;

    localparam int DEPTH = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SRD, S_SCAN, S_MRD, S_MWR, S_TRD, S_TOUT
    } t_state;

    t_state          r_state;
    logic [PW-1:0]   r_cfg;
    logic [PW-1:0]   r_hint;
    logic [15:0]     r_idx;
    logic [15:0]     r_len;
    logic [PW-1:0]   r_pos;
    logic [PW-1:0]   r_cnt;
    logic [PW-1:0]   r_run;
    logic            r_retry;
    logic [PW-1:0]   r_lo;
    logic [PW-1:0]   r_hi;
    logic            r_set;
    logic [AW-1:0]   r_waddr;
    logic [AW-1:0]   r_wlast;
    logic            r_done;
    logic [1:0]      r_status;
    logic [15:0]     r_startb;
    logic            r_bitv;

    logic [PW-1:0]        size;
    logic [PW-1:0]        range_end;
    logic [PW-1:0]        alloc_end;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] mask;
    logic [AW-1:0]        ram_addr;
    logic                 ram_we;
    logic                 ram_re;
    t_scan_res            scan;

    // Size beyond storage acts as the storage size.
    assign size = (32'(r_cfg) > MAX_BLOCKS) ? PW'(MAX_BLOCKS) : r_cfg;
    assign range_end = PW'(i_block_index) + PW'(i_run_length);
    assign alloc_end = scan.start + PW'(r_len);

    function automatic logic [AW-1:0] word_of(input logic [PW-1:0] pos);
        return AW'(32'(pos) / WORD_BITS);
    endfunction

    bra_scan #(.WORD_BITS(WORD_BITS)) u_scan (
        .i_word  (rd_data),
        .i_pos   (r_pos),
        .i_size  (size),
        .i_len   (r_len),
        .i_count (r_cnt),
        .i_start (r_run),
        .o_res   (scan)
    );

    // Range mask for the word under modification.
    always_comb begin
        logic [31:0] g;
        for (int b = 0; b < WORD_BITS; b++) begin
            g = (32'(r_waddr) << LW) | 32'(b);
            mask[b] = (g >= 32'(r_lo)) && (g < 32'(r_hi));
        end
    end

    assign wr_data = (r_state == S_INIT) ? '1 :
                     (r_set ? (rd_data | mask) : (rd_data & ~mask));

    always_comb begin
        case (r_state)
            S_SRD:   ram_addr = word_of(r_pos);
            S_TRD:   ram_addr = word_of(PW'(r_idx));
            default: ram_addr = r_waddr;
        endcase
    end

    assign ram_we = (r_state == S_INIT) || (r_state == S_MWR);
    assign ram_re = (r_state == S_SRD) || (r_state == S_MRD) || (r_state == S_TRD);

    bra_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (wr_data),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cfg   <= PW'(65536);
            r_hint  <= '0;
            r_waddr <= '0;
            r_done  <= 1'b0;
            r_retry <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_bitmap_size;
            end
            case (r_state)
                S_INIT: begin
                    // Sweep the store to all used.
                    r_waddr <= r_waddr + AW'(1);
                    if (r_waddr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_idx    <= i_block_index;
                        r_len    <= i_run_length;
                        r_status <= ST_OK;
                        r_startb <= '0;
                        r_bitv   <= 1'b0;
                        case (i_mode)
                            MODE_ALLOC: begin
                                r_retry <= 1'b0;
                                r_cnt   <= '0;
                                r_pos   <= (r_hint == '0) ? PW'(1) : r_hint;
                                if (i_run_length == '0) begin
                                    r_status <= ST_NO_SPACE;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_SRD;
                                end
                            end
                            MODE_FREE, MODE_MARK: begin
                                r_lo    <= PW'(i_block_index);
                                r_hi    <= range_end;
                                r_set   <= (i_mode == MODE_MARK);
                                r_waddr <= word_of(PW'(i_block_index));
                                r_wlast <= word_of(range_end - PW'(1));
                                if (range_end > size) begin
                                    r_status <= ST_BOUNDS;
                                    r_done   <= 1'b1;
                                end else begin
                                    if (i_mode == MODE_FREE) begin
                                        r_hint <= PW'(i_block_index);
                                    end
                                    if (i_run_length == '0) begin
                                        r_done <= 1'b1;
                                    end else begin
                                        r_state <= S_MRD;
                                    end
                                end
                            end
                            default: begin
                                if (PW'(i_block_index) >= size) begin
                                    r_status <= ST_BOUNDS;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_TRD;
                                end
                            end
                        endcase
                    end
                end
                S_SRD: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_cnt <= scan.count;
                    r_run <= scan.start;
                    r_pos <= scan.next_pos;
                    if (scan.found) begin
                        // Hold the run and mark it used.
                        r_hint   <= alloc_end;
                        r_startb <= scan.start[15:0];
                        r_lo     <= scan.start;
                        r_hi     <= alloc_end;
                        r_set    <= 1'b1;
                        r_waddr  <= word_of(scan.start);
                        r_wlast  <= word_of(alloc_end - PW'(1));
                        r_state  <= S_MRD;
                    end else if (scan.next_pos >= size) begin
                        if (!r_retry && r_hint != '0) begin
                            // Retry once from the start of the bitmap.
                            r_hint  <= '0;
                            r_retry <= 1'b1;
                            r_pos   <= PW'(1);
                            r_cnt   <= '0;
                            r_state <= S_SRD;
                        end else begin
                            r_status <= ST_NO_SPACE;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else if (scan.next_pos[LW-1:0] == '0) begin
                        r_state <= S_SRD;
                    end
                end
                S_MRD: begin
                    r_state <= S_MWR;
                end
                S_MWR: begin
                    r_waddr <= r_waddr + AW'(1);
                    if (r_waddr == r_wlast) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_MRD;
                    end
                end
                S_TRD: begin
                    r_state <= S_TOUT;
                end
                S_TOUT: begin
                    r_bitv  <= rd_data[LW'(32'(r_idx) % WORD_BITS)];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_start_block = r_startb;
    assign o_bit_value   = r_bitv;
    assign o_cfg_ready   = 1'b1;
endmodule

// ----- hdl/bra_ram.sv -----
// Generic single-port RAM with a registered read port.
// Depends on nothing; used for the bitmap store.
module bra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/bra_scan.sv -----
// One step of the free-run search: up to eight bits of the current word.
// Depends on bra_pkg for the position width, step length and result struct.
module bra_scan #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0]   i_word,
    input  logic [bra_pkg::PW-1:0] i_pos,
    input  logic [bra_pkg::PW-1:0] i_size,
    input  logic [15:0]            i_len,
    input  logic [bra_pkg::PW-1:0] i_count,
    input  logic [bra_pkg::PW-1:0] i_start,
    output bra_pkg::t_scan_res     o_res
);
    import bra_pkg::*;

    localparam int LW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    always_comb begin
        logic [PW-1:0] p;
        logic [PW-1:0] cnt;
        logic [PW-1:0] st;
        logic [PW-1:0] nxt;
        logic          found;
        logic          stop;
        int            bo;
        int            off;
        cnt   = i_count;
        st    = i_start;
        nxt   = i_pos;
        found = 1'b0;
        stop  = 1'b0;
        bo    = int'(i_pos % WORD_BITS);
        for (int j = 0; j < STEP; j++) begin
            p   = i_pos + PW'(j);
            off = bo + j;
            if (!found && !stop) begin
                if (off >= WORD_BITS || p >= i_size) begin
                    stop = 1'b1;
                end else begin
                    nxt = p + PW'(1);
                    if (!i_word[LW'(off)]) begin
                        if (cnt == '0) begin
                            st = p;
                        end
                        cnt = cnt + PW'(1);
                        if (cnt == {1'b0, i_len}) begin
                            found = 1'b1;
                        end
                    end else begin
                        cnt = '0;
                    end
                end
            end
        end
        o_res.found    = found;
        o_res.start    = st;
        o_res.count    = cnt;
        o_res.next_pos = nxt;
    end
endmodule

// ----- hdl/bra_checker.sv -----
// Port-level checks for the bitmap run allocator, bound to the top level.
// Depends on bra_pkg for the status codes.
module bra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [15:0] o_start_block,
    input logic        o_bit_value
);
    import bra_pkg::*;

    // An accepted item either answers at once or keeps the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("accepted item neither answered nor raised busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result shown while busy");

    // Without an accepted item or work in flight no result appears.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && !i_start) |=> !o_done)
        else $error("result without an item");

    a_fail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_start_block == '0 && !o_bit_value))
        else $error("failed item carries data");
endmodule

bind bitmap_run_allocator_top bra_checker u_bra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_start_block (o_start_block),
    .o_bit_value   (o_bit_value)
);

// ----- tb/tb_top.sv -----
// Testbench for bitmap_run_allocator_top: random and directed commands, checked
// against an in-bench allocator predictor. Depends on bra_pkg and the hdl files.
`timescale 1ns / 100ps

// One expected result item.
typedef struct {
    logic [1:0]  status;
    logic [15:0] start_block;
    logic        bit_value;
} alloc_result_t;

// Tracks the allocator state and compares each result with the oldest
// prediction.
class alloc_scoreboard;
    bit            used_map [65536];
    logic [16:0]   hint;
    logic [16:0]   map_size;
    alloc_result_t pending [$];
    int            mismatches;

    function new();
        foreach (used_map[i]) used_map[i] = 1'b1;
        hint       = '0;
        map_size   = 17'd65536;
        mismatches = 0;
    endfunction

    function void set_size(logic [16:0] v);
        map_size = v;
    endfunction

    // First free run of len blocks from 'from' on, never block 0; 0 if none.
    function int find_run(int from, int len, int lim);
        int count;
        int first;
        count = 0;
        first = 0;
        if (from == 0) from = 1;
        for (int i = from; i < lim; i++) begin
            if (!used_map[i]) begin
                if (count == 0) first = i;
                count++;
                if (count == len) return first;
            end else begin
                count = 0;
            end
        end
        return 0;
    endfunction

    // Predict the result of one accepted command and advance the state.
    function void note_item(logic [1:0] mode, logic [15:0] idx, logic [15:0] len);
        alloc_result_t r;
        int lim;
        int run_start;
        lim = (map_size > 17'd65536) ? 65536 : int'(map_size);
        r.status      = bra_pkg::ST_OK;
        r.start_block = '0;
        r.bit_value   = 1'b0;
        if (mode == bra_pkg::MODE_ALLOC) begin
            run_start = 0;
            if (len != 0) begin
                run_start = find_run(int'(hint), int'(len), lim);
                if (run_start == 0 && hint != 0) begin
                    hint      = '0;
                    run_start = find_run(0, int'(len), lim);
                end
            end
            if (run_start == 0) begin
                r.status = bra_pkg::ST_NO_SPACE;
            end else begin
                for (int i = 0; i < int'(len); i++) used_map[run_start + i] = 1'b1;
                hint          = 17'(run_start + int'(len));
                r.start_block = 16'(run_start);
            end
        end else if (mode == bra_pkg::MODE_FREE || mode == bra_pkg::MODE_MARK) begin
            if (int'(idx) + int'(len) > lim) begin
                r.status = bra_pkg::ST_BOUNDS;
            end else begin
                for (int i = 0; i < int'(len); i++)
                    used_map[int'(idx) + i] = (mode == bra_pkg::MODE_MARK);
                if (mode == bra_pkg::MODE_FREE) hint = {1'b0, idx};
            end
        end else begin
            if (int'(idx) >= lim) r.status = bra_pkg::ST_BOUNDS;
            else r.bit_value = used_map[idx];
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] sb, logic bv);
        alloc_result_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: status %0d start %0d bit %0d", st, sb, bv);
            return;
        end
        e = pending.pop_front();
        if (st !== e.status || sb !== e.start_block || bv !== e.bit_value) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp status %0d start %0d bit %0d, got %0d %0d %0d",
                         e.status, e.start_block, e.bit_value, st, sb, bv);
        end
    endfunction
endclass

module tb_top;
    import bra_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [1:0]  i_mode = MODE_TEST;
    logic [15:0] i_block_index = '0;
    logic [15:0] i_run_length = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [15:0] o_start_block;
    logic        o_bit_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_bitmap_size = 17'd65536;

    alloc_scoreboard alloc_sb = new();
    bit no_idle;

    bitmap_run_allocator_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_mode            (i_mode),
        .i_block_index     (i_block_index),
        .i_run_length      (i_run_length),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_start_block     (o_start_block),
        .o_bit_value       (o_bit_value),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_bitmap_size (i_cfg_bitmap_size)
    );

    always #5 i_clk = ~i_clk;

    // Results cannot be held off: check every strobed item as it appears.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) alloc_sb.check_result(o_status, o_start_block, o_bit_value);
    end

    // Hard stop in case the block hangs; the slowest legal run is far shorter.
    initial begin
        #200_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Present one command and hold it until the block takes it. Called and
    // returning at a rising edge; start stays high so a back-to-back item
    // needs no second assignment in the same step.
    task automatic send_item(logic [1:0] mode, logic [15:0] idx, logic [15:0] len);
        int gap;
        i_start       <= 1'b1;
        i_mode        <= mode;
        i_block_index <= idx;
        i_run_length  <= len;
        do @(posedge i_clk); while (o_busy);
        alloc_sb.note_item(mode, idx, len);
        // Draw the gap before the next item; drop start only when idling.
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait until every predicted result has come back, then settle a little.
    task automatic drain();
        i_start <= 1'b0;
        while (alloc_sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the size register; only called with the block idle.
    task automatic write_size(logic [16:0] v);
        drain();
        i_cfg_bitmap_size <= v;
        i_cfg_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        alloc_sb.set_size(v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random commands for one size setting: mostly in-range work with
    // short runs so allocations succeed and fail often, plus raw noise.
    task automatic random_phase(int lim, int n);
        int span;
        int pick;
        logic [1:0]  mode;
        logic [15:0] idx;
        logic [15:0] len;
        span = (lim < 1) ? 1 : lim;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            idx  = 16'($urandom_range(0, span - 1));
            len  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, span))
                                                : 16'($urandom_range(1, 12));
            if (pick < 32) mode = MODE_ALLOC;
            else if (pick < 62) mode = MODE_FREE;
            else if (pick < 77) mode = MODE_MARK;
            else mode = MODE_TEST;
            // Keep most ranges inside the map so the state keeps moving.
            if (mode != MODE_ALLOC && mode != MODE_TEST && int'(idx) + int'(len) > lim
                && pick % 4 != 0)
                len = 16'(span - int'(idx));
            if (pick >= 95) begin
                // Noise: every bit of the fields toggles, mostly out of bounds.
                mode = 2'($urandom_range(1, 3));
                idx  = 16'($urandom);
                len  = 16'($urandom);
            end
            if (k == n / 2 && lim == 100) begin
                // Hold off until the block has answered everything.
                drain();
            end
            send_item(mode, idx, len);
        end
    endtask

    initial begin
        int sizes [9] = '{100, 1, 0, 64, 257, 1024, 33, 500, 2};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full map at reset size, edges of the fields and the hint.
        no_idle = 0;
        send_item(MODE_TEST,  16'd0,     16'd0);
        send_item(MODE_TEST,  16'hffff,  16'd0);
        send_item(MODE_ALLOC, 16'd0,     16'd0);      // zero length
        send_item(MODE_ALLOC, 16'hffff,  16'd1);      // full map, no space
        send_item(MODE_FREE,  16'hffff,  16'd1);
        send_item(MODE_ALLOC, 16'd0,     16'd1);      // hits the last block
        send_item(MODE_ALLOC, 16'd0,     16'd1);      // hint past end, retry
        send_item(MODE_MARK,  16'hffff,  16'd2);      // out of bounds
        send_item(MODE_FREE,  16'd0,     16'hffff);
        send_item(MODE_MARK,  16'd1,     16'hffff);
        send_item(MODE_FREE,  16'd10,    16'd0);      // empty range moves hint
        send_item(MODE_MARK,  16'd0,     16'd0);
        send_item(MODE_ALLOC, 16'd0,     16'hffff);
        send_item(MODE_FREE,  16'd1,     16'd20);
        send_item(MODE_ALLOC, 16'h5a5a,  16'd20);
        send_item(MODE_TEST,  16'd5,     16'd0);
        send_item(MODE_TEST,  16'd0,     16'd0);

        // Size above storage acts as the full map.
        write_size(17'h1ffff);
        send_item(MODE_TEST,  16'hffff,  16'd0);
        send_item(MODE_FREE,  16'd100,   16'd16);
        send_item(MODE_ALLOC, 16'd0,     16'd8);
        send_item(MODE_MARK,  16'hfff0,  16'd16);
        no_idle = 1;
        random_phase(65536, 6);

        foreach (sizes[s]) begin
            write_size(17'(sizes[s]));
            no_idle = ($urandom_range(0, 3) == 0);
            random_phase(sizes[s], 100);
        end

        write_size(17'd65536);
        no_idle = 0;
        random_phase(65536, 6);

        drain();
        repeat (20) @(posedge i_clk);
        if (alloc_sb.mismatches == 0 && alloc_sb.pending.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hdl/bra_pkg.sv
hdl/bra_ram.sv
hdl/bra_scan.sv
hdl/bitmap_run_allocator_top.sv
hdl/bra_checker.sv
tb/tb_top.sv
